/* hdl/mba_pkg.sv */
package mba_pkg;

  // Store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  // Field widths
  localparam int CMD_W    = 3;
  localparam int POS_W    = 16;
  localparam int OFS_W    = 15;
  localparam int VAL_W    = 8;
  localparam int PIX_W    = 32;
  localparam int ALPHA_SHIFT = 24;

  // Signed width for coordinate arithmetic: base plus offset and clipping
  localparam int CW = POS_W + 2;

  // Configuration port
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_DIM_RESET   = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_PLOT  = 3'd0,
    CMD_FILL  = 3'd1,
    CMD_STAMP = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // Memory access from the sequencer to the store
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
  } mem_req_t;

endpackage

/* hdl/mba_if.sv */
// Request channel
interface mba_req_if;
  logic                               valid;
  logic                               ready;
  logic        [mba_pkg::CMD_W-1:0]   cmd;
  logic signed [mba_pkg::POS_W-1:0]   pos_x;
  logic signed [mba_pkg::POS_W-1:0]   pos_y;
  logic signed [mba_pkg::POS_W-1:0]   end_x;
  logic signed [mba_pkg::POS_W-1:0]   end_y;
  logic        [mba_pkg::OFS_W-1:0]   offset_x;
  logic        [mba_pkg::OFS_W-1:0]   offset_y;
  logic        [mba_pkg::VAL_W-1:0]   opacity;
  logic        [mba_pkg::PIX_W-1:0]   pixel_word;

  modport source (
    output valid, cmd, pos_x, pos_y, end_x, end_y, offset_x, offset_y, opacity, pixel_word,
    input  ready
  );
  modport sink (
    input  valid, cmd, pos_x, pos_y, end_x, end_y, offset_x, offset_y, opacity, pixel_word,
    output ready
  );
endinterface

// Response channel
interface mba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mba_pkg::VAL_W-1:0]    read_value;
  logic                         in_bounds;

  modport source (output valid, read_value, in_bounds, input ready);
  modport sink   (input  valid, read_value, in_bounds, output ready);
endinterface

/* hdl/mba_store.sv */
module mba_store (
  input  logic                          clk_i,
  input  mba_pkg::mem_req_t             mem_req_i,
  output logic [mba_pkg::VAL_W-1:0]     rdata_o
);

  logic [mba_pkg::VAL_W-1:0] mem [mba_pkg::DEPTH];
  logic [mba_pkg::VAL_W-1:0] rdata_q;

  // One write port, one registered read port; read data holds when idle
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= mem[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/mba_ctrl.sv */
module mba_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mba_pkg::CFG_W-1:0]     width_i,
  input  logic [mba_pkg::CFG_W-1:0]     height_i,
  mba_req_if.sink                       req,
  mba_rsp_if.source                     rsp,
  output mba_pkg::mem_req_t             mem_req_o,
  input  logic [mba_pkg::VAL_W-1:0]     rdata_i
);

  localparam int CW = mba_pkg::CW;
  localparam int XW = mba_pkg::XW;
  localparam int YW = mba_pkg::YW;
  localparam int AW = mba_pkg::ADDR_W;
  localparam int VW = mba_pkg::VAL_W;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  function automatic logic in_mask(input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y,
                                   input logic signed [CW-1:0] w,
                                   input logic signed [CW-1:0] h);
    in_mask = (x >= 0) && (y >= 0) && (x < w) && (y < h);
  endfunction

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic            clr_reply_q, clr_reply_d;
  logic            p_valid_q, p_valid_d;
  logic            out_valid_q, out_valid_d;

  logic [AW-1:0]   p_addr_q, p_addr_d;
  logic [VW-1:0]   val_q, val_d;
  logic            wr_q, wr_d;
  logic            rd_q, rd_d;
  logic            ib_q, ib_d;
  logic [XW-1:0]   x0_q, x0_d, x1_q, x1_d, cx_q, cx_d;
  logic [YW-1:0]   y1_q, y1_d, cy_q, cy_d;
  logic [VW-1:0]   out_rv_q, out_rv_d;
  logic            out_ib_q, out_ib_d;

  // Decode of the incoming request
  logic signed [CW-1:0] px, py, ex, ey, ox, oy, tx, ty;
  logic signed [CW-1:0] w_ext, h_ext, aw, ah;
  logic signed [CW-1:0] lx, rx, ty0, by;
  logic [VW-1:0]        alpha;
  logic                 hit, dec_ne, dec_wr, dec_rd, dec_ib;
  logic [VW-1:0]        dec_val;

  logic                 acc;
  logic                 last_cell;
  logic                 last_clr;
  logic                 rsp_free;
  logic [AW-1:0]        cur_addr;
  logic                 do_write;

  assign req.ready = (state_q == ST_IDLE);
  assign acc       = req.valid && req.ready;
  assign rsp_free  = !out_valid_q || rsp.ready;
  assign last_cell = (cx_q == x1_q) && (cy_q == y1_q);
  assign last_clr  = (clr_cnt_q == AW'(mba_pkg::DEPTH - 1));
  assign cur_addr  = AW'(cy_q) * AW'(mba_pkg::MAX_WIDTH) + AW'(cx_q);
  assign do_write  = p_valid_q && wr_q && (val_q > rdata_i);

  // Clip the request against the active mask
  always_comb begin
    px    = CW'(req.pos_x);
    py    = CW'(req.pos_y);
    ex    = CW'(req.end_x);
    ey    = CW'(req.end_y);
    ox    = CW'(req.offset_x);
    oy    = CW'(req.offset_y);
    tx    = px + ox;
    ty    = py + oy;
    w_ext = CW'(width_i);
    h_ext = CW'(height_i);
    aw    = (w_ext > CW'(mba_pkg::MAX_WIDTH))  ? CW'(mba_pkg::MAX_WIDTH)  : w_ext;
    ah    = (h_ext > CW'(mba_pkg::MAX_HEIGHT)) ? CW'(mba_pkg::MAX_HEIGHT) : h_ext;
    alpha = req.pixel_word[mba_pkg::ALPHA_SHIFT +: VW];
    lx      = px;
    rx      = px;
    ty0     = py;
    by      = py;
    hit     = in_mask(px, py, aw, ah);
    dec_ne  = 1'b0;
    dec_wr  = 1'b0;
    dec_rd  = 1'b0;
    dec_ib  = 1'b0;
    dec_val = req.opacity;
    unique case (req.cmd)
      mba_pkg::CMD_PLOT: begin
        dec_ib = hit;
        dec_ne = hit;
        dec_wr = 1'b1;
      end
      mba_pkg::CMD_STAMP: begin
        lx      = tx;
        rx      = tx;
        ty0     = ty;
        by      = ty;
        hit     = in_mask(tx, ty, aw, ah);
        dec_ib  = hit;
        dec_ne  = hit && (alpha != '0);
        dec_wr  = 1'b1;
        dec_val = alpha;
      end
      mba_pkg::CMD_READ: begin
        dec_ib = hit;
        dec_ne = hit;
        dec_rd = hit;
      end
      mba_pkg::CMD_FILL: begin
        lx     = (px < 0) ? '0 : px;
        ty0    = (py < 0) ? '0 : py;
        rx     = (ex > aw - CW'(1)) ? aw - CW'(1) : ex;
        by     = (ey > ah - CW'(1)) ? ah - CW'(1) : ey;
        dec_ne = (lx <= rx) && (ty0 <= by);
        dec_wr = 1'b1;
      end
      default: begin
        dec_ne = 1'b0;
      end
    endcase
  end

  // Sequencer: clearing sweep, cell walk with read-modify-write, response
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    clr_reply_d = clr_reply_q;
    p_valid_d   = 1'b0;
    p_addr_d    = cur_addr;
    out_valid_d = out_valid_q && !rsp.ready;
    val_d       = val_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    ib_d        = ib_q;
    x0_d        = x0_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    out_rv_d    = out_rv_q;
    out_ib_d    = out_ib_q;

    mem_req_o       = '0;
    mem_req_o.raddr = cur_addr;
    mem_req_o.waddr = p_addr_q;
    mem_req_o.wdata = val_q;
    mem_req_o.we    = do_write;

    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_cnt_q;
        mem_req_o.wdata = '0;
        clr_cnt_d       = last_clr ? '0 : clr_cnt_q + AW'(1);
        if (last_clr) begin
          state_d     = clr_reply_q ? ST_RESULT : ST_IDLE;
          clr_reply_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          val_d = dec_val;
          wr_d  = dec_wr;
          rd_d  = dec_rd;
          ib_d  = dec_ib;
          x0_d  = lx[XW-1:0];
          x1_d  = rx[XW-1:0];
          y1_d  = by[YW-1:0];
          cx_d  = lx[XW-1:0];
          cy_d  = ty0[YW-1:0];
          if (req.cmd == mba_pkg::CMD_CLEAR) begin
            state_d     = ST_CLEAR;
            clr_reply_d = 1'b1;
          end else if (dec_ne) begin
            state_d = ST_RUN;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_RUN: begin
        mem_req_o.re = 1'b1;
        p_valid_d    = 1'b1;
        if (cx_q == x1_q) begin
          cx_d = x0_q;
          cy_d = cy_q + YW'(1);
        end else begin
          cx_d = cx_q + XW'(1);
        end
        if (last_cell) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (rsp_free) begin
          out_valid_d = 1'b1;
          out_rv_d    = rd_q ? rdata_i : '0;
          out_ib_d    = ib_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_reply_q <= 1'b0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_reply_q <= clr_reply_d;
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    p_addr_q <= p_addr_d;
    val_q    <= val_d;
    wr_q     <= wr_d;
    rd_q     <= rd_d;
    ib_q     <= ib_d;
    x0_q     <= x0_d;
    x1_q     <= x1_d;
    y1_q     <= y1_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    out_rv_q <= out_rv_d;
    out_ib_q <= out_ib_d;
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.read_value = out_rv_q;
  assign rsp.in_bounds  = out_ib_q;

endmodule

/* hdl/max_blend_alpha_mask.sv */
// Max-blend coverage mask over a 256 x 256 store of 8-bit cells held in one
// synchronous RAM (one write port, one registered read port). Apart from a
// clear, cells only rise: plot, stamp and fill write a cell only where the new
// value is greater. After reset the block sweeps the RAM to zero and takes no
// request meanwhile; configuration writes are taken at any time. Plot, stamp
// and read that land inside the mask go through accept, RAM read and response
// with write-back; a fill reads each clipped cell in turn, and a plot, stamp or
// read outside the mask, a stamp with zero alpha, an empty fill or an unknown
// request go from accept straight to the response; a clear sweeps every cell
// to zero first. Responses sit in an output register, so a request is accepted
// while the previous response still waits to be taken.
module max_blend_alpha_mask (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mba_pkg::CFG_W-1:0]     cfg_wdata_i,
  mba_req_if.sink                       req_i,
  mba_rsp_if.source                     rsp_o
);

  logic [mba_pkg::CFG_W-1:0] width_q, width_d;
  logic [mba_pkg::CFG_W-1:0] height_q, height_d;
  mba_pkg::mem_req_t         mem_req;
  logic [mba_pkg::VAL_W-1:0] rdata;

  // Decode configuration writes
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mba_pkg::CFG_MASK_WIDTH:  width_d  = cfg_wdata_i;
        mba_pkg::CFG_MASK_HEIGHT: height_d = cfg_wdata_i;
        default:                  width_d  = width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mba_pkg::CFG_DIM_RESET;
      height_q <= mba_pkg::CFG_DIM_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  mba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .width_i   (width_q),
    .height_i  (height_q),
    .req       (req_i),
    .rsp       (rsp_o),
    .mem_req_o (mem_req),
    .rdata_i   (rdata)
  );

  mba_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  // A nonzero read value only comes from a cell inside the mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.read_value != '0) |-> rsp_o.in_bounds)
    else $error("read value without in_bounds");

  // Write-back never hits the cell being read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we && mem_req.re |-> (mem_req.waddr != mem_req.raddr))
    else $error("read and write collide on one cell");

  // One request at a time: accept drops ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while busy");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import mba_pkg::*;

  localparam int unsigned RUN_LIMIT = 3_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS = 210;
  localparam int POS_MAX = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN = -(2 ** (POS_W - 1));
  localparam int OFS_MAX = 2 ** OFS_W - 1;

  // Command codes that the block does not decode
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] end_x;
    logic signed [POS_W-1:0] end_y;
    logic [OFS_W-1:0]        offset_x;
    logic [OFS_W-1:0]        offset_y;
    logic [VAL_W-1:0]        opacity;
    logic [PIX_W-1:0]        pixel_word;
  } mask_req_t;

  typedef struct {
    logic [VAL_W-1:0] read_value;
    logic             in_bounds;
  } mask_rsp_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  mba_req_if req_bus ();
  mba_rsp_if rsp_bus ();

  max_blend_alpha_mask i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // Predicted coverage store and size registers
  logic [VAL_W-1:0] cov_store [DEPTH];
  logic [CFG_W-1:0] mask_w_reg;
  logic [CFG_W-1:0] mask_h_reg;
  mask_rsp_t        pending_replies [$];

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_en = 1'b1;
  int          hold_req_cycles = 0;
  int          hold_left = 0;
  int          stall_left = 0;
  int          clears_left = 3;

  always #5 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int active_dim(logic [CFG_W-1:0] r, int lim);
    return (int'(r) > lim) ? lim : int'(r);
  endfunction

  function automatic bit cell_inside(int x, int y);
    return x >= 0 && y >= 0 && x < active_dim(mask_w_reg, MAX_WIDTH) &&
           y < active_dim(mask_h_reg, MAX_HEIGHT);
  endfunction

  function automatic void raise_cell(int x, int y, logic [VAL_W-1:0] v);
    int a;
    if (!cell_inside(x, y)) return;
    a = y * MAX_WIDTH + x;
    if (v > cov_store[a]) cov_store[a] = v;
  endfunction

  function automatic mask_rsp_t predict_mask_reply(mask_req_t it);
    mask_rsp_t        rsp;
    int               px, py, ex, ey, tx, ty, l, t, r, b;
    logic [VAL_W-1:0] alpha;
    px = it.pos_x;
    py = it.pos_y;
    ex = it.end_x;
    ey = it.end_y;
    rsp.read_value = '0;
    rsp.in_bounds = 1'b0;
    case (it.cmd)
      CMD_PLOT: begin
        rsp.in_bounds = cell_inside(px, py);
        raise_cell(px, py, it.opacity);
      end
      CMD_FILL: begin
        // Clip to the active mask; an inverted rectangle writes nothing
        l = (px < 0) ? 0 : px;
        t = (py < 0) ? 0 : py;
        r = (ex > active_dim(mask_w_reg, MAX_WIDTH) - 1) ?
            active_dim(mask_w_reg, MAX_WIDTH) - 1 : ex;
        b = (ey > active_dim(mask_h_reg, MAX_HEIGHT) - 1) ?
            active_dim(mask_h_reg, MAX_HEIGHT) - 1 : ey;
        for (int y = t; y <= b; y++)
          for (int x = l; x <= r; x++)
            raise_cell(x, y, it.opacity);
      end
      CMD_STAMP: begin
        tx = px + int'(it.offset_x);
        ty = py + int'(it.offset_y);
        alpha = VAL_W'(it.pixel_word >> ALPHA_SHIFT);
        rsp.in_bounds = cell_inside(tx, ty);
        if (alpha != '0) raise_cell(tx, ty, alpha);
      end
      CMD_CLEAR: begin
        foreach (cov_store[i]) cov_store[i] = '0;
      end
      CMD_READ: begin
        if (cell_inside(px, py)) begin
          rsp.in_bounds = 1'b1;
          rsp.read_value = cov_store[py * MAX_WIDTH + px];
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [POS_W-1:0] to_pos(int v);
    if (v > POS_MAX) return POS_W'(POS_MAX);
    if (v < POS_MIN) return POS_W'(POS_MIN);
    return POS_W'(v);
  endfunction

  function automatic mask_req_t blank_req(logic [CMD_W-1:0] cmd);
    mask_req_t it;
    it.cmd = cmd;
    it.pos_x = '0;
    it.pos_y = '0;
    it.end_x = '0;
    it.end_y = '0;
    it.offset_x = '0;
    it.offset_y = '0;
    it.opacity = '0;
    it.pixel_word = '0;
    return it;
  endfunction

  // Coordinate mostly near the active area, sometimes on its far edge or anywhere
  function automatic int near_coord(int act);
    int                      span;
    logic signed [POS_W-1:0] raw;
    span = (act > 24) ? 24 : act;
    raw = $urandom;
    case ($urandom_range(0, 15))
      0:       return raw;
      1:       return act - 1 + int'($urandom_range(0, 1));
      default: return int'($urandom_range(0, span + 3)) - 2;
    endcase
  endfunction

  function automatic int pick_offset(int target);
    int ofs;
    ofs = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 40)) :
                                         int'($urandom_range(0, OFS_MAX));
    // Keep the base within the signed field
    if (target - ofs < POS_MIN) ofs = target - POS_MIN;
    return ofs;
  endfunction

  function automatic mask_req_t random_mask_req();
    mask_req_t it;
    int        w, h, px, py, tx, ty, ox, oy, pick;
    w = active_dim(mask_w_reg, MAX_WIDTH);
    h = active_dim(mask_h_reg, MAX_HEIGHT);
    // Start from noise in every field, then shape the ones that matter
    it.cmd = CMD_PLOT;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.end_x = $urandom;
    it.end_y = $urandom;
    it.offset_x = $urandom;
    it.offset_y = $urandom;
    it.opacity = $urandom;
    it.pixel_word = $urandom;
    pick = $urandom_range(0, 99);
    if (clears_left > 0 && $urandom_range(0, 249) == 0) begin
      clears_left--;
      it.cmd = CMD_CLEAR;
    end else if (pick < 22) begin
      it.pos_x = to_pos(near_coord(w));
      it.pos_y = to_pos(near_coord(h));
    end else if (pick < 38) begin
      it.cmd = CMD_FILL;
      px = near_coord(w);
      py = near_coord(h);
      it.pos_x = to_pos(px);
      it.pos_y = to_pos(py);
      it.end_x = to_pos(px + int'($urandom_range(0, 12)) - 2);
      it.end_y = to_pos(py + int'($urandom_range(0, 12)) - 2);
    end else if (pick < 55) begin
      it.cmd = CMD_STAMP;
      tx = near_coord(w);
      ty = near_coord(h);
      ox = pick_offset(tx);
      oy = pick_offset(ty);
      it.pos_x = to_pos(tx - ox);
      it.pos_y = to_pos(ty - oy);
      it.offset_x = OFS_W'(ox);
      it.offset_y = OFS_W'(oy);
      if ($urandom_range(0, 5) == 0) it.pixel_word[ALPHA_SHIFT +: VAL_W] = '0;
    end else if (pick < 58) begin
      it.cmd = CMD_STAMP;
    end else if (pick < 90) begin
      it.cmd = CMD_READ;
      it.pos_x = to_pos(near_coord(w));
      it.pos_y = to_pos(near_coord(h));
    end else if (pick < 96) begin
      it.cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    return it;
  endfunction

  // Offer one request, hold it until taken, then maybe pause
  task automatic send_req(input mask_req_t it);
    int gap;
    req_bus.valid <= 1'b1;
    req_bus.cmd <= it.cmd;
    req_bus.pos_x <= it.pos_x;
    req_bus.pos_y <= it.pos_y;
    req_bus.end_x <= it.end_x;
    req_bus.end_y <= it.end_y;
    req_bus.offset_x <= it.offset_x;
    req_bus.offset_y <= it.offset_y;
    req_bus.opacity <= it.opacity;
    req_bus.pixel_word <= it.pixel_word;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    pending_replies.push_back(predict_mask_reply(it));
    if (idle_en && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_point(input logic [CMD_W-1:0] cmd, input int x, input int y,
                            input int op);
    mask_req_t it;
    it = blank_req(cmd);
    it.pos_x = to_pos(x);
    it.pos_y = to_pos(y);
    it.opacity = VAL_W'(op);
    send_req(it);
  endtask

  task automatic send_fill(input int l, input int t, input int r, input int b, input int op);
    mask_req_t it;
    it = blank_req(CMD_FILL);
    it.pos_x = to_pos(l);
    it.pos_y = to_pos(t);
    it.end_x = to_pos(r);
    it.end_y = to_pos(b);
    it.opacity = VAL_W'(op);
    send_req(it);
  endtask

  task automatic send_stamp(input int px, input int py, input int ox, input int oy,
                            input logic [PIX_W-1:0] word);
    mask_req_t it;
    it = blank_req(CMD_STAMP);
    it.pos_x = to_pos(px);
    it.pos_y = to_pos(py);
    it.offset_x = OFS_W'(ox);
    it.offset_y = OFS_W'(oy);
    it.pixel_word = word;
    send_req(it);
  endtask

  // Drop the request, wait until every predicted reply has come back and the
  // block has settled
  task automatic wait_mask_idle();
    req_bus.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mask_size(input int w, input int h);
    wait_mask_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MASK_WIDTH;
    cfg_wdata_i <= CFG_W'(w);
    @(posedge clk_i);
    cfg_idx_i <= CFG_MASK_HEIGHT;
    cfg_wdata_i <= CFG_W'(h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mask_w_reg = CFG_W'(w);
    mask_h_reg = CFG_W'(h);
  endtask

  // ---------------------------------------------------------------------------
  // Reply side: random back-pressure and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (hold_req_cycles != 0) begin
      hold_left = hold_req_cycles;
      hold_req_cycles = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_replies
    mask_rsp_t want;
    if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply: expected none, actual read_value %0d in_bounds %0d",
                 $time, rsp_bus.read_value, rsp_bus.in_bounds);
        err_cnt++;
      end else begin
        want = pending_replies.pop_front();
        if (rsp_bus.read_value !== want.read_value) begin
          $display("%0t: read_value mismatch: expected %0d, actual %0d",
                   $time, want.read_value, rsp_bus.read_value);
          err_cnt++;
        end
        if (rsp_bus.in_bounds !== want.in_bounds) begin
          $display("%0t: in_bounds mismatch: expected %0d, actual %0d",
                   $time, want.in_bounds, rsp_bus.in_bounds);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Points, reads and stamps at the corners and far outside the full mask
  task automatic test_plot_read_stamp();
    send_point(CMD_PLOT, 0, 0, 255);
    send_point(CMD_PLOT, 255, 255, 1);
    send_point(CMD_PLOT, -1, 0, 9);
    send_point(CMD_PLOT, 256, 3, 9);
    send_point(CMD_PLOT, POS_MAX, POS_MIN, 9);
    send_point(CMD_READ, 0, 0, 0);
    send_point(CMD_READ, POS_MIN, POS_MAX, 0);
    send_point(CMD_READ, 256, 0, 0);
    // A lower value must not lower a cell
    send_point(CMD_PLOT, 0, 0, 10);
    send_point(CMD_READ, 0, 0, 0);
    send_stamp(-100, -5, 100, 5, 32'h80AB_CDEF);
    // Zero alpha writes nothing but still reports the target
    send_stamp(3, 4, 0, 0, 32'h00FF_FFFF);
    send_point(CMD_READ, 3, 4, 0);
    send_stamp(POS_MIN, 0, OFS_MAX, 0, 32'hFF00_0000);
    send_stamp(POS_MAX, POS_MAX, OFS_MAX, OFS_MAX, 32'hFFFF_FFFF);
    send_stamp(5, 2, 250, 253, 32'hC000_0000);
    send_point(CMD_READ, 255, 255, 0);
  endtask

  // Empty, small and whole-mask fills, spare codes and a clear
  task automatic test_fill_and_clear();
    send_fill(10, 10, 9, 20, 50);
    send_fill(2, 2, 5, 3, 127);
    send_point(CMD_READ, 3, 2, 0);
    send_req(blank_req(CMD_SPARE_LO));
    send_req(blank_req(CMD_SPARE_HI));
    send_fill(POS_MIN, POS_MIN, POS_MAX, POS_MAX, 64);
    send_point(CMD_READ, 100, 100, 0);
    send_req(blank_req(CMD_CLEAR));
    send_point(CMD_READ, 0, 0, 0);
  endtask

  // Zero size, oversized values, and data kept across a size change
  task automatic test_mask_dimensions();
    set_mask_size(0, 0);
    send_point(CMD_PLOT, 0, 0, 200);
    send_fill(0, 0, 5, 5, 200);
    send_point(CMD_READ, 0, 0, 0);
    set_mask_size(511, 1);
    send_point(CMD_PLOT, 255, 0, 77);
    send_point(CMD_READ, 256, 0, 0);
    send_point(CMD_READ, 255, 1, 0);
    set_mask_size(1, 256);
    send_point(CMD_READ, 255, 0, 0);
    send_point(CMD_READ, 0, 255, 0);
    set_mask_size(256, 256);
    send_point(CMD_READ, 255, 0, 0);
  endtask

  // Hold off replies for a long stretch while requests keep coming
  task automatic test_reply_hold_off();
    set_mask_size(8, 8);
    idle_en = 1'b0;
    hold_req_cycles = HOLD_OFF_CYCLES;
    repeat (30) send_req(random_mask_req());
    idle_en = 1'b1;
  endtask

  // Random traffic over a range of mask sizes; the last phase runs without idling
  task automatic test_random_phases();
    int phase_w [8] = '{16, 0, 300, 1, 9, 256, 511, 37};
    int phase_h [8] = '{16, 5, 12, 1, 200, 256, 511, 3};
    for (int p = 0; p < 8; p++) begin
      set_mask_size(phase_w[p], phase_h[p]);
      idle_en = (p != 7);
      repeat (PHASE_ITEMS) send_req(random_mask_req());
    end
  endtask

  initial begin
    req_bus.valid = 1'b0;
    req_bus.cmd = '0;
    req_bus.pos_x = '0;
    req_bus.pos_y = '0;
    req_bus.end_x = '0;
    req_bus.end_y = '0;
    req_bus.offset_x = '0;
    req_bus.offset_y = '0;
    req_bus.opacity = '0;
    req_bus.pixel_word = '0;
    rsp_bus.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MASK_WIDTH;
    cfg_wdata_i = '0;
    foreach (cov_store[i]) cov_store[i] = '0;
    mask_w_reg = CFG_DIM_RESET;
    mask_h_reg = CFG_DIM_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_plot_read_stamp();
    test_fill_and_clear();
    test_mask_dimensions();
    test_reply_hold_off();
    test_random_phases();

    wait_mask_idle();
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
